// File: rtl/kthanc_pkg.sv
package kthanc_pkg;

    localparam int NODES     = 1024;
    localparam int LEVELS    = 10;
    localparam int NODE_W    = 10;
    localparam int VALUE_W   = 10;
    localparam int LVL_W     = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int S_TDATA_W = ((NODE_W + VALUE_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((NODE_W + 7) / 8) * 8;

    typedef enum logic
    {
        CMD_LOAD  = 1'b0,
        CMD_QUERY = 1'b1
    } cmd_t;

    typedef logic [NODE_W-1:0] node_t;
    typedef logic [LEVELS-1:0][NODE_W-1:0] row_t;

    typedef struct packed
    {
        logic             clr;
        logic             wr_en;
        node_t            wr_row;
        logic [LVL_W-1:0] wr_lvl;
        node_t            wr_data;
        logic             rd_en;
        node_t            rd_row;
    } mem_req_t;

    typedef struct packed
    {
        logic  valid;
        node_t ancestor;
    } result_t;

endpackage

// File: rtl/kthanc_mem.sv
module kthanc_mem
(
    input  logic                 clk,
    input  kthanc_pkg::mem_req_t req,
    output kthanc_pkg::row_t     rd_data
);
    import kthanc_pkg::*;

    row_t mem [NODES];

    always_ff @(posedge clk)
    begin
        if (req.clr)
        begin
            mem[req.wr_row] <= '0;
        end
        else if (req.wr_en)
        begin
            mem[req.wr_row][req.wr_lvl] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_data <= mem[req.rd_row];
        end
    end

endmodule

// File: rtl/kthanc_walk.sv
module kthanc_walk
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  kthanc_pkg::cmd_t          in_cmd,
    input  kthanc_pkg::node_t         in_node,
    input  logic [kthanc_pkg::VALUE_W-1:0] in_value,
    output kthanc_pkg::mem_req_t      req,
    input  kthanc_pkg::row_t          rd_data,
    output kthanc_pkg::result_t       res,
    input  logic                      res_ready
);
    import kthanc_pkg::*;

    typedef enum logic [3:0]
    {
        ST_CLEAR = 4'b0001,
        ST_IDLE  = 4'b0010,
        ST_RUN   = 4'b0100,
        ST_HOLD  = 4'b1000
    } state_t;

    state_t             state_reg, state_next;
    logic [LVL_W-1:0]   lvl_reg, lvl_next;
    node_t              cur_reg, cur_next;
    node_t              node_reg, node_next;
    logic [LEVELS-1:0]  k_reg, k_next;
    cmd_t               cmd_reg, cmd_next;
    node_t              clr_row_reg, clr_row_next;

    node_t              sel;
    node_t              parent;
    logic               node_ok;
    logic               in_node_ok;
    logic               last;

    assign in_ready   = (state_reg == ST_IDLE);
    assign node_ok    = (node_reg != '0) && (32'(node_reg) < NODES);
    assign in_node_ok = (in_node != '0) && (32'(in_node) < NODES);
    assign parent     = (32'(in_value) < NODES) ? NODE_W'(in_value) : '0;

    always_comb
    begin
        if (cmd_reg == CMD_LOAD)
        begin
            // The row being filled may be read back right after a write to it.
            sel  = (cur_reg == node_reg) ? cur_reg : rd_data[lvl_reg];
            last = (lvl_reg == LVL_W'(LEVELS - 2));
        end
        else
        begin
            sel  = k_reg[lvl_reg] ? rd_data[lvl_reg] : cur_reg;
            last = (lvl_reg == LVL_W'(LEVELS - 1));
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        lvl_next     = lvl_reg;
        cur_next     = cur_reg;
        node_next    = node_reg;
        k_next       = k_reg;
        cmd_next     = cmd_reg;
        clr_row_next = clr_row_reg;
        req          = '0;
        res.valid    = 1'b0;
        res.ancestor = cur_reg;

        unique case (state_reg)
            ST_CLEAR:
            begin
                req.clr      = 1'b1;
                req.wr_row   = clr_row_reg;
                clr_row_next = clr_row_reg + NODE_W'(1);
                if (clr_row_reg == NODE_W'(NODES - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next  = in_cmd;
                    node_next = in_node;
                    k_next    = LEVELS'(in_value);
                    lvl_next  = '0;
                    if (in_cmd == CMD_LOAD)
                    begin
                        cur_next     = parent;
                        req.wr_en    = in_node_ok;
                        req.wr_row   = in_node;
                        req.wr_lvl   = '0;
                        req.wr_data  = parent;
                        state_next   = (LEVELS > 1) ? ST_RUN : ST_IDLE;
                    end
                    else
                    begin
                        if ((32'(in_node) >= NODES) || ((32'(in_value) >> LEVELS) != 0))
                        begin
                            cur_next = '0;
                        end
                        else
                        begin
                            cur_next = in_node;
                        end
                        state_next = ST_RUN;
                    end
                    req.rd_en  = 1'b1;
                    req.rd_row = cur_next;
                end
            end
            ST_RUN:
            begin
                cur_next   = sel;
                req.rd_en  = 1'b1;
                req.rd_row = sel;
                if (cmd_reg == CMD_LOAD)
                begin
                    req.wr_en   = node_ok;
                    req.wr_row  = node_reg;
                    req.wr_lvl  = lvl_reg + LVL_W'(1);
                    req.wr_data = sel;
                end
                if (last)
                begin
                    state_next = (cmd_reg == CMD_LOAD) ? ST_IDLE : ST_HOLD;
                end
                else
                begin
                    lvl_next = lvl_reg + LVL_W'(1);
                end
            end
            ST_HOLD:
            begin
                res.valid = 1'b1;
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            clr_row_reg <= '0;
            lvl_reg     <= '0;
            cmd_reg     <= CMD_LOAD;
        end
        else
        begin
            state_reg   <= state_next;
            clr_row_reg <= clr_row_next;
            lvl_reg     <= lvl_next;
            cmd_reg     <= cmd_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg  <= cur_next;
        node_reg <= node_next;
        k_reg    <= k_next;
    end

endmodule

// File: rtl/kth_ancestor_binary_lifting.sv
// Load transfer: the block stays busy, with one table read per level.
// Query transfer: the result reaches the output register after a chain of dependent
// table reads; the next item is taken once the output register has taken the result.
// After reset the table is cleared one row per cycle, all NODES (1024) rows, with
// s_tready low; control registers reset asynchronously, the table has no reset.
module kth_ancestor_binary_lifting
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [kthanc_pkg::S_TDATA_W-1:0] s_tdata,  // node, value, zero pad
    input  logic [0:0]                       s_tuser,  // cmd
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [kthanc_pkg::M_TDATA_W-1:0] m_tdata,  // ancestor, zero pad
    output logic [0:0]                       m_tuser   // found
);
    import kthanc_pkg::*;

    mem_req_t req;
    row_t     rd_data;
    result_t  res;
    logic     res_ready;
    cmd_t     in_cmd;

    logic     m_tvalid_reg, m_tvalid_next;
    node_t    ancestor_reg, ancestor_next;

    assign in_cmd = cmd_t'(s_tuser[0]);

    kthanc_walk u_walk
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_cmd    (in_cmd),
        .in_node   (s_tdata[NODE_W-1:0]),
        .in_value  (s_tdata[NODE_W+VALUE_W-1:NODE_W]),
        .req       (req),
        .rd_data   (rd_data),
        .res       (res),
        .res_ready (res_ready)
    );

    kthanc_mem u_mem
    (
        .clk     (clk),
        .req     (req),
        .rd_data (rd_data)
    );

    assign res_ready = !m_tvalid_reg || m_tready;

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        ancestor_next = ancestor_reg;
        if (res_ready)
        begin
            m_tvalid_next = res.valid;
            if (res.valid)
            begin
                ancestor_next = res.ancestor;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ancestor_reg <= ancestor_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = M_TDATA_W'(ancestor_reg);
    assign m_tuser  = (ancestor_reg != '0);

endmodule
